// File: src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the triangle face normal pipeline
// Widths of the request and result items, internal datapath widths and the
// sideband record that travels next to the square root and divider stages.
// ----------------------------------------------------------------------------
package tfn_pkg;

	// field widths
	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int INDEX_BITS       = 16;
	localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;

	// normalized magnitudes have their top bit at NORM_TOP-1
	localparam int NORM_TOP = 30;

	// datapath widths
	localparam int EDGE_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = CROSS_W;
	localparam int POS_W   = $clog2(MAG_W);
	localparam int SQ_W    = 2 * NORM_TOP;
	localparam int SUM_W   = 2 * NORM_TOP + 2;
	localparam int ROOT_W  = NORM_TOP + 1;
	localparam int SQRT_STEPS = NORM_TOP + 1;
	localparam int DIV_STEPS  = NORMAL_FRAC_BITS + 1;
	localparam int DIV_W   = NORM_TOP + NORMAL_FRAC_BITS + 2;
	localparam int QUO_W   = NORMAL_FRAC_BITS + 1;

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		index_t a_index;
		index_t b_index;
		index_t c_index;
	} index_set_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
		index_t a_index;
		index_t b_index;
		index_t c_index;
	} request_t;

	typedef struct packed {
		logic signed [NORMAL_BITS-1:0] normal_x;
		logic signed [NORMAL_BITS-1:0] normal_y;
		logic signed [NORMAL_BITS-1:0] normal_z;
		logic                          degenerate;
		index_t                        out_a_index;
		index_t                        out_b_index;
		index_t                        out_c_index;
	} result_t;

	// per-item record carried beside the root and quotient stages
	typedef struct packed {
		logic [2:0][NORM_TOP-1:0] mag;
		logic [2:0]               neg;
		logic                     degenerate;
		index_set_t               idx;
	} side_t;

endpackage

// File: src/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front: edge vectors, cross product and normalization
// Eight register stages: edges, products, cross, magnitude, leading bit,
// shift to a fixed top bit, squares and the sum of squares.
// ----------------------------------------------------------------------------
module tfn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  tfn_pkg::request_t  req,
	output logic               out_valid,
	output tfn_pkg::side_t     side,
	output logic [tfn_pkg::SUM_W-1:0] sum
);

	localparam int EW = tfn_pkg::EDGE_W;
	localparam int PW = tfn_pkg::PROD_W;
	localparam int CW = tfn_pkg::CROSS_W;
	localparam int MW = tfn_pkg::MAG_W;
	localparam int NT = tfn_pkg::NORM_TOP;
	localparam int SHW = MW + NT - 1;

	logic [8:1] valid_s;

	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [CW-1:0] cr_s3 [3];
	logic [MW-1:0]        mag_s4 [3];
	logic [2:0]           neg_s4;
	logic [MW-1:0]        mag_s5 [3];
	logic [2:0]           neg_s5;
	logic [tfn_pkg::POS_W-1:0] pos_s5;
	logic                 deg_s5;
	logic [NT-1:0]        v_s6 [3];
	logic [2:0]           neg_s6;
	logic                 deg_s6;
	logic [NT-1:0]        v_s7 [3];
	logic [tfn_pkg::SQ_W-1:0] sq_s7 [3];
	logic [2:0]           neg_s7;
	logic                 deg_s7;
	logic [NT-1:0]        v_s8 [3];
	logic [tfn_pkg::SUM_W-1:0] sum_s8;
	logic [2:0]           neg_s8;
	logic                 deg_s8;
	tfn_pkg::index_set_t  idx_s [8:1];

	logic [MW-1:0]        mag_or;
	logic [tfn_pkg::POS_W-1:0] pos_c;
	logic [SHW-1:0]       wide_c [3];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[7:1], in_valid};
		end
	end

	// find the leading one of the largest magnitude
	always_comb begin
		mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];
		pos_c  = '0;
		for (int i = 0; i < MW; i++) begin
			if (mag_or[i]) begin
				pos_c = tfn_pkg::POS_W'(i);
			end
		end
	end

	// place the leading one at bit NT-1, truncating below
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_c[i] = {mag_s5[i], {(NT-1){1'b0}}} >> pos_s5;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		// edges
		e1_s1[0] <= EW'(req.b_x) - EW'(req.a_x);
		e1_s1[1] <= EW'(req.b_y) - EW'(req.a_y);
		e1_s1[2] <= EW'(req.b_z) - EW'(req.a_z);
		e2_s1[0] <= EW'(req.c_x) - EW'(req.b_x);
		e2_s1[1] <= EW'(req.c_y) - EW'(req.b_y);
		e2_s1[2] <= EW'(req.c_z) - EW'(req.b_z);
		idx_s[1] <= '{a_index: req.a_index, b_index: req.b_index, c_index: req.c_index};

		// partial products of the cross product
		p_s2[0] <= PW'(e1_s1[1]) * PW'(e2_s1[2]);
		p_s2[1] <= PW'(e1_s1[2]) * PW'(e2_s1[1]);
		p_s2[2] <= PW'(e1_s1[2]) * PW'(e2_s1[0]);
		p_s2[3] <= PW'(e1_s1[0]) * PW'(e2_s1[2]);
		p_s2[4] <= PW'(e1_s1[0]) * PW'(e2_s1[1]);
		p_s2[5] <= PW'(e1_s1[1]) * PW'(e2_s1[0]);
		idx_s[2] <= idx_s[1];

		// cross components
		for (int i = 0; i < 3; i++) begin
			cr_s3[i] <= CW'(p_s2[2*i]) - CW'(p_s2[2*i+1]);
		end
		idx_s[3] <= idx_s[2];

		// sign and magnitude
		for (int i = 0; i < 3; i++) begin
			neg_s4[i] <= cr_s3[i][CW-1];
			mag_s4[i] <= cr_s3[i][CW-1] ? MW'(-cr_s3[i]) : MW'(cr_s3[i]);
		end
		idx_s[4] <= idx_s[3];

		// leading bit
		mag_s5   <= mag_s4;
		neg_s5   <= neg_s4;
		pos_s5   <= pos_c;
		deg_s5   <= (mag_or == '0);
		idx_s[5] <= idx_s[4];

		// normalize
		for (int i = 0; i < 3; i++) begin
			v_s6[i] <= wide_c[i][NT-1:0];
		end
		neg_s6   <= neg_s5;
		deg_s6   <= deg_s5;
		idx_s[6] <= idx_s[5];

		// squares
		for (int i = 0; i < 3; i++) begin
			sq_s7[i] <= tfn_pkg::SQ_W'(v_s6[i]) * tfn_pkg::SQ_W'(v_s6[i]);
		end
		v_s7     <= v_s6;
		neg_s7   <= neg_s6;
		deg_s7   <= deg_s6;
		idx_s[7] <= idx_s[6];

		// sum of squares
		sum_s8   <= tfn_pkg::SUM_W'(sq_s7[0]) + tfn_pkg::SUM_W'(sq_s7[1])
			+ tfn_pkg::SUM_W'(sq_s7[2]);
		v_s8     <= v_s7;
		neg_s8   <= neg_s7;
		deg_s8   <= deg_s7;
		idx_s[8] <= idx_s[7];
	end

	assign out_valid       = valid_s[8];
	assign sum             = sum_s8;
	assign side.mag[0]     = v_s8[0];
	assign side.mag[1]     = v_s8[1];
	assign side.mag[2]     = v_s8[2];
	assign side.neg        = neg_s8;
	assign side.degenerate = deg_s8;
	assign side.idx        = idx_s[8];

endmodule

// File: src/tfn_sqrt.sv
// ----------------------------------------------------------------------------
// tfn_sqrt: pipelined integer square root
// One result bit per register stage; the root of the sum of squares leaves
// after SQRT_STEPS stages together with the item's sideband record.
// ----------------------------------------------------------------------------
module tfn_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  tfn_pkg::side_t             in_side,
	input  logic [tfn_pkg::SUM_W-1:0]  sum,
	output logic                       out_valid,
	output tfn_pkg::side_t             out_side,
	output logic [tfn_pkg::ROOT_W-1:0] root
);

	localparam int N  = tfn_pkg::SQRT_STEPS;
	localparam int SW = tfn_pkg::SUM_W;

	logic [N:0]           valid_s;
	logic [SW-1:0]        x_s [N+1];
	logic [SW-1:0]        r_s [N+1];
	tfn_pkg::side_t       side_s [N+1];

	assign x_s[0]    = sum;
	assign r_s[0]    = '0;
	assign side_s[0] = in_side;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[N:1] <= '0;
		end else begin
			valid_s[N:1] <= valid_s[N-1:0];
		end
	end
	assign valid_s[0] = in_valid;

	// one trial subtraction per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - 1 - k));
		logic [SW-1:0] trial;
		logic          fits;

		assign trial = r_s[k] + BIT;
		assign fits  = (x_s[k] >= trial);

		always_ff @(posedge clk) begin
			x_s[k+1]    <= fits ? (x_s[k] - trial) : x_s[k];
			r_s[k+1]    <= fits ? ((r_s[k] >> 1) + BIT) : (r_s[k] >> 1);
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[N];
	assign out_side  = side_s[N];
	assign root      = r_s[N][tfn_pkg::ROOT_W-1:0];

endmodule

// File: src/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div: pipelined rounded division of the three components by the norm
// One entry stage forms the rounded numerators, then one quotient bit per
// stage in three lanes that share the divisor.
// ----------------------------------------------------------------------------
module tfn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  tfn_pkg::side_t             in_side,
	input  logic [tfn_pkg::ROOT_W-1:0] root,
	output logic                       out_valid,
	output tfn_pkg::side_t             out_side,
	output logic [2:0][tfn_pkg::QUO_W-1:0] quo
);

	localparam int N  = tfn_pkg::DIV_STEPS;
	localparam int DW = tfn_pkg::DIV_W;
	localparam int QW = tfn_pkg::QUO_W;

	logic [N+1:0]           valid_s;
	logic [2:0][DW-1:0]     rem_s [N+1];
	logic [2:0][QW-1:0]     quo_s [N+1];
	logic [tfn_pkg::ROOT_W-1:0] den_s [N+1];
	tfn_pkg::side_t         side_s [N+1];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[N+1:1] <= '0;
		end else begin
			valid_s[N+1:1] <= valid_s[N:0];
		end
	end
	assign valid_s[0] = in_valid;

	// form numerators with half the divisor for round to nearest
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] <= (DW'(in_side.mag[i]) << tfn_pkg::NORMAL_FRAC_BITS)
				+ DW'(root >> 1);
		end
		quo_s[0]  <= '0;
		den_s[0]  <= root;
		side_s[0] <= in_side;
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int SH = N - 1 - k;
		logic [DW-1:0] dsh;

		assign dsh = DW'(den_s[k]) << SH;

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_s[k][i] >= dsh) begin
					rem_s[k+1][i] <= rem_s[k][i] - dsh;
					quo_s[k+1][i] <= quo_s[k][i] | (QW'(1) << SH);
				end else begin
					rem_s[k+1][i] <= rem_s[k][i];
					quo_s[k+1][i] <= quo_s[k][i];
				end
			end
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[N+1];
	assign out_side  = side_s[N];
	assign quo       = quo_s[N];

endmodule

// File: src/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of one triangle per request
// Usage: drive a triangle (three signed Q8.8 vertices and three vertex
// indices) on tri_in and raise start; the request is taken at any rising
// edge with start high and busy low. busy stays low: the pipeline takes a
// new request in every cycle.
// Each request gives one result on the result port, marked by done for
// exactly one cycle. Results leave in request order.
// The path runs through the square root (one root bit per stage, 31 stages)
// and the divider (one quotient bit per stage, 15 stages plus entry),
// behind eight stages of cross product and normalization.
// The normal is signed Q1.14, rounded to nearest; a zero cross product
// gives a zero normal with degenerate set. Indices pass through.
// The receiver cannot stall; results must be taken as they appear.
// Reset clears all valid bits, so no done pulse follows reset by itself.
// ----------------------------------------------------------------------------
module triangle_face_normal (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tfn_pkg::request_t tri_in,
	output logic              done,
	output tfn_pkg::result_t  result
);

	localparam int NB      = tfn_pkg::NORMAL_BITS;
	localparam int LATENCY = tfn_pkg::NORMAL_FRAC_BITS + 42;

	logic                 front_valid;
	tfn_pkg::side_t       front_side;
	logic [tfn_pkg::SUM_W-1:0] front_sum;
	logic                 sqrt_valid;
	tfn_pkg::side_t       sqrt_side;
	logic [tfn_pkg::ROOT_W-1:0] sqrt_root;
	logic                 div_valid;
	tfn_pkg::side_t       div_side;
	logic [2:0][tfn_pkg::QUO_W-1:0] div_quo;

	logic                 done_q;
	tfn_pkg::result_t     result_q;
	logic signed [NB-1:0] norm_c [3];

	assign busy = 1'b0;

	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.req       (tri_in),
		.out_valid (front_valid),
		.side      (front_side),
		.sum       (front_sum)
	);

	tfn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_side   (front_side),
		.sum       (front_sum),
		.out_valid (sqrt_valid),
		.out_side  (sqrt_side),
		.root      (sqrt_root)
	);

	tfn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sqrt_valid),
		.in_side   (sqrt_side),
		.root      (sqrt_root),
		.out_valid (div_valid),
		.out_side  (div_side),
		.quo       (div_quo)
	);

	// apply signs, zero the degenerate case
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (div_side.degenerate) begin
				norm_c[i] = '0;
			end else if (div_side.neg[i]) begin
				norm_c[i] = -NB'(div_quo[i]);
			end else begin
				norm_c[i] = NB'(div_quo[i]);
			end
		end
	end

	// hold the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		result_q.normal_x    <= norm_c[0];
		result_q.normal_y    <= norm_c[1];
		result_q.normal_z    <= norm_c[2];
		result_q.degenerate  <= div_side.degenerate;
		result_q.out_a_index <= div_side.idx.a_index;
		result_q.out_b_index <= div_side.idx.b_index;
		result_q.out_c_index <= div_side.idx.c_index;
	end

	assign done   = done_q;
	assign result = result_q;

	// every result traces back to a request that the pipeline took earlier
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	// a degenerate triangle gives a zero normal
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |->
			result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0)
		else $error("degenerate result with nonzero normal");

	// a proper triangle gives a nonzero normal
	a_normal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.degenerate |->
			result.normal_x != '0 || result.normal_y != '0 || result.normal_z != '0)
		else $error("zero normal on a proper triangle");

endmodule
